/* rtl/polar_angle_sort_macros.svh */
// Assertion macros shared by the polar angle sort checker.
`ifndef POLAR_ANGLE_SORT_MACROS_SVH
`define POLAR_ANGLE_SORT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define PAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/pas_pkg.sv */
// Package with shared constants, types and the arctangent table of the polar angle sort.
package pas_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int TOL_BITS       = 11;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 11'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new point and start conversion, unless the set is full
    logic cmp_rd;   // read the pair at the compare index
    logic cmp_wr;   // write back the pair, swapped if needed
    logic out_rd;   // read the entry at the output index
    logic clr_set;  // clear count and drop flag
  } pas_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic full;
  } pas_sts_t;

  // Arctangent table, 2^32 units per turn.
  function automatic logic [31:0] atan_turns(input logic [3:0] i);
    logic [31:0] r;
    begin
      case (i)
        4'd0: r = 32'h20000000;  4'd1: r = 32'h12E4051E;
        4'd2: r = 32'h09FB385B;  4'd3: r = 32'h051111D4;
        4'd4: r = 32'h028B0D43;  4'd5: r = 32'h0145D7E1;
        4'd6: r = 32'h00A2F61E;  4'd7: r = 32'h00517C55;
        4'd8: r = 32'h0028BE53;  4'd9: r = 32'h00145F2F;
        4'd10: r = 32'h000A2F98; 4'd11: r = 32'h000517CC;
        4'd12: r = 32'h00028BE6; 4'd13: r = 32'h000145F3;
        4'd14: r = 32'h0000A2FA; default: r = 32'h0000517D;
      endcase
      return r;
    end
  endfunction
endpackage

/* rtl/pas_in_if.sv */
// Stream interfaces for points in and polar words out.
interface pas_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic                         set_end;
  modport source (output valid, coord_x, coord_y, set_end, input ready);
  modport sink   (input valid, coord_x, coord_y, set_end, output ready);
endinterface

interface pas_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] radius;
  logic [15:0] angle;
  logic        overflowed;
  logic        final_point;
  modport source (output valid, radius, angle, overflowed, final_point, input ready);
  modport sink   (input valid, radius, angle, overflowed, final_point, output ready);
endinterface

/* rtl/pas_datapath.sv */
// Datapath: square root and CORDIC units, point store and compare-swap.
module pas_datapath #(
  parameter int MAX_POINTS = pas_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pas_pkg::COORD_BITS_DEF,
  localparam int IW = $clog2(MAX_POINTS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pas_pkg::pas_cmd_t             cmd,
  output pas_pkg::pas_sts_t             sts,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  input  logic [pas_pkg::TOL_BITS-1:0]  tol,
  input  logic [IW-1:0]                 cmp_idx,
  input  logic [IW-1:0]                 out_idx,
  output logic [15:0]                   rd_radius,
  output logic [15:0]                   rd_angle,
  output logic                          drop,
  output logic [IW:0]                   count
);
  import pas_pkg::*;

  localparam int SW = 2 * COORD_BITS + 2;           // sum of squares, even width
  localparam int RW = (SW + 1) / 2;                 // root width
  localparam int SQ_STEPS = RW;
  localparam int CW = COORD_BITS + 17;              // CORDIC word
  localparam int SQW = $clog2(SQ_STEPS + 1);

  // Conversion phases: squares, sum, iterate, done.
  typedef enum logic [2:0] {
    P_IDLE, P_SQUARE, P_SUM, P_ITER, P_DONE
  } phase_t;

  // Squares computed in P_SQUARE and summed in P_SUM, then a one-bit-per-step root.
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic [2*COORD_BITS-1:0] sx_r, sy_r;
  logic [SW-1:0]  sum_r, rem_r;
  logic [RW+1:0]  root_r;
  logic [SQW-1:0] sq_cnt_r;
  phase_t         phase_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic [31:0] acc_r;
  logic [4:0]  ci_r;
  logic        cz_r;
  logic [15:0] res_radius, res_angle;

  logic [SW+1:0] trial;
  logic signed [CW-1:0] dx, dy;
  logic [2*RW+3:0] rr;

  // Restoring root on two bits of the sum per step.
  logic [SW+1:0] rem_w, pair_w;
  logic [SW-1:0] sum_sh_nxt;
  always_comb begin
    pair_w = (SW+2)'(sum_r[SW-1 -: 2]);
    rem_w  = ((SW+2)'(rem_r) << 2) | pair_w;
    trial  = ((SW+2)'(root_r) << 2) | (SW+2)'(1);
    sum_sh_nxt = sum_r << 2;
    dx = cy_r >>> ci_r;
    dy = cx_r >>> ci_r;
    rr = (2*RW+4)'(root_r) * (2*RW+4)'(root_r);
  end

  logic [2*RW+3:0] sum_ext;
  assign sum_ext = (2*RW+4)'(sx_r + sy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      unique case (phase_r)
        P_IDLE: if (cmd.load && !sts.full) begin
          x_r <= coord_x;
          y_r <= coord_y;
          phase_r <= P_SQUARE;
        end
        P_SQUARE: begin
          sx_r <= (2*COORD_BITS)'($signed(x_r) * $signed(x_r));
          sy_r <= (2*COORD_BITS)'($signed(y_r) * $signed(y_r));
          cz_r <= (x_r == '0) && (y_r == '0);
          if (x_r < 0) begin
            cx_r <= -(CW'(x_r) <<< 14);
            cy_r <= -(CW'(y_r) <<< 14);
            acc_r <= 32'h80000000;
          end else begin
            cx_r <= CW'(x_r) <<< 14;
            cy_r <= CW'(y_r) <<< 14;
            acc_r <= '0;
          end
          ci_r <= '0;
          phase_r <= P_SUM;
        end
        P_SUM: begin
          sum_r    <= SW'(sum_ext);
          rem_r    <= '0;
          root_r   <= '0;
          sq_cnt_r <= '0;
          phase_r  <= P_ITER;
        end
        P_ITER: begin
          if (sq_cnt_r != SQW'(SQ_STEPS)) begin
            sum_r <= sum_sh_nxt;
            if (rem_w >= trial) begin
              rem_r  <= SW'(rem_w - trial);
              root_r <= (root_r << 1) | (RW+2)'(1);
            end else begin
              rem_r  <= SW'(rem_w);
              root_r <= root_r << 1;
            end
            sq_cnt_r <= sq_cnt_r + 1'b1;
          end
          // One CORDIC step per cycle in parallel, stopping after the last step.
          if (ci_r != 5'(CORDIC_STEPS)) begin
            if (cy_r >= 0) begin
              cx_r  <= cx_r + dx;
              cy_r  <= cy_r - dy;
              acc_r <= acc_r + atan_turns(ci_r[3:0]);
            end else begin
              cx_r  <= cx_r - dx;
              cy_r  <= cy_r + dy;
              acc_r <= acc_r - atan_turns(ci_r[3:0]);
            end
            ci_r <= ci_r + 1'b1;
          end
          if (sq_cnt_r == SQW'(SQ_STEPS) && ci_r == 5'(CORDIC_STEPS)) phase_r <= P_DONE;
        end
        P_DONE: phase_r <= P_IDLE;
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  // Rounding and saturation of the finished root; angle from accumulator.
  logic [2*RW+3:0] diff;
  logic [RW+1:0]   root_rnd;
  always_comb begin
    diff     = sum_ext - rr;
    root_rnd = (diff > (2*RW+4)'(root_r)) ? root_r + 1'b1 : root_r;
    res_radius = (root_rnd > (RW+2)'(16'hFFFF)) ? 16'hFFFF : root_rnd[15:0];
    res_angle  = cz_r ? 16'd0 : 16'((acc_r + 32'h8000) >> 16);
  end
  assign sts.conv_done = (phase_r == P_DONE);
  assign sts.full      = (count == (IW+1)'(MAX_POINTS));

  // Point store and set state.
  logic [15:0] rad_mem [MAX_POINTS];
  logic [15:0] ang_mem [MAX_POINTS];
  logic [IW:0] count_r;
  logic        drop_r;
  logic [15:0] lo_r_r, lo_a_r, hi_r_r, hi_a_r;
  logic        do_swap;

  always_comb begin
    do_swap = (hi_a_r < lo_a_r) ||
              ((17'(hi_a_r) - 17'(lo_a_r) < 17'(tol)) && (hi_r_r > lo_r_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.clr_set) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end else if (cmd.load && sts.full) begin
        drop_r <= 1'b1;
      end else if (sts.conv_done) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Memory writes: conversion result, or a compare-swap write-back.
  always_ff @(posedge clk) begin
    if (sts.conv_done) begin
      rad_mem[count_r[IW-1:0]] <= res_radius;
      ang_mem[count_r[IW-1:0]] <= res_angle;
    end else if (cmd.cmp_wr && do_swap) begin
      rad_mem[cmp_idx]      <= lo_r_r;
      ang_mem[cmp_idx]      <= lo_a_r;
      rad_mem[cmp_idx - 1'b1] <= hi_r_r;
      ang_mem[cmp_idx - 1'b1] <= hi_a_r;
    end
    if (cmd.cmp_rd) begin
      hi_r_r <= rad_mem[cmp_idx];
      hi_a_r <= ang_mem[cmp_idx];
      lo_r_r <= rad_mem[cmp_idx - 1'b1];
      lo_a_r <= ang_mem[cmp_idx - 1'b1];
    end
    if (cmd.out_rd) begin
      rd_radius <= rad_mem[out_idx];
      rd_angle  <= ang_mem[out_idx];
    end
  end

  assign drop  = drop_r;
  assign count = count_r;
endmodule

/* rtl/pas_ctrl.sv */
// Controller: sequences conversion, bubble passes and output of a set.
module pas_ctrl #(
  parameter int MAX_POINTS = pas_pkg::MAX_POINTS_DEF,
  localparam int IW = $clog2(MAX_POINTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_set_end,
  output logic              in_ready,
  input  pas_pkg::pas_sts_t sts,
  input  logic [IW:0]       count,
  input  logic              drop,
  output pas_pkg::pas_cmd_t cmd,
  output logic [IW-1:0]     cmp_idx,
  output logic [IW-1:0]     out_idx,
  input  logic [15:0]       rd_radius,
  input  logic [15:0]       rd_angle,
  pas_out_if.source         res
);
  import pas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_PASS, S_CMPW, S_OREAD, S_OWAIT, S_OSHOW
  } state_t;

  state_t      state_r;
  logic        last_r;
  logic [IW:0] j_r, k_r, o_r;
  logic        ovf_r;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.load    = in_valid && in_ready;
  assign cmd.cmp_rd  = (state_r == S_PASS) && (k_r > j_r);
  assign cmd.cmp_wr  = (state_r == S_CMPW);
  assign cmd.out_rd  = (state_r == S_OREAD);
  assign cmd.clr_set = (state_r == S_OSHOW) && res.ready && (o_r + 1'b1 == count);
  assign cmp_idx     = k_r[IW-1:0];
  assign out_idx     = o_r[IW-1:0];

  assign res.valid       = (state_r == S_OSHOW);
  assign res.radius      = rd_radius;
  assign res.angle       = rd_angle;
  assign res.overflowed  = ovf_r;
  assign res.final_point = (o_r + 1'b1 == count);

  // State and registered control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      j_r <= '0; k_r <= '0; o_r <= '0; ovf_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (cmd.load) begin
          last_r  <= in_set_end;
          state_r <= sts.full ? (in_set_end ? S_PASS : S_IDLE) : S_CONV;
          j_r <= '0;
          k_r <= count - 1'b1;
        end
        S_CONV: if (sts.conv_done) begin
          j_r <= '0;
          k_r <= count;
          state_r <= last_r ? S_PASS : S_IDLE;
        end
        S_PASS: begin
          ovf_r <= drop;
          if (count == '0) begin
            state_r <= S_IDLE;
          end else if (k_r > j_r) begin
            state_r <= S_CMPW;
          end else if (j_r + 2'd2 < count + 1'b1) begin
            j_r <= j_r + 1'b1;
            k_r <= count - 1'b1;
          end else begin
            o_r <= '0;
            state_r <= S_OREAD;
          end
        end
        S_CMPW: begin
          k_r <= k_r - 1'b1;
          state_r <= S_PASS;
        end
        S_OREAD: state_r <= S_OWAIT;
        S_OWAIT: state_r <= S_OSHOW;
        S_OSHOW: if (res.ready) begin
          if (o_r + 1'b1 == count) state_r <= S_IDLE;
          else begin
            o_r <= o_r + 1'b1;
            state_r <= S_OREAD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/polar_angle_sort.sv */
// Top level of the polar angle sort: points in, sorted polar words out.
//
//  channel | dir | handshake        | payload
//  in      | in  | valid/ready      | coord_x, coord_y, set_end
//  out     | out | valid/ready      | radius, angle, overflowed, final_point
//  cfg     | in  | cfg_we           | cfg_wdata (angle tolerance)
//
// After a point is taken the input is held off while it is converted: the squares, their
// sum, then the one-bit-per-cycle square root, with the CORDIC running alongside it.
// A point dropped from a full set costs no conversion.
// The sort runs n-1 bubble passes, each compare a read and then a write-back.
// Each output word is read, waited on and shown, and held while out_ready is low.
// Reset is synchronous and active low; the store itself needs no clearing.
module polar_angle_sort #(
  parameter int MAX_POINTS = pas_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pas_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pas_in_if.sink                       in_ch,
  pas_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [pas_pkg::TOL_BITS-1:0] cfg_wdata
);
  import pas_pkg::*;
  localparam int IW = $clog2(MAX_POINTS);

  pas_cmd_t cmd;
  pas_sts_t sts;
  logic [TOL_BITS-1:0] tol_r;
  logic [IW-1:0] cmp_idx, out_idx;
  logic [15:0] rd_radius, rd_angle;
  logic drop;
  logic [IW:0] count;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_RESET;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  pas_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_set_end(in_ch.set_end),
    .in_ready(in_ch.ready), .sts, .count, .drop, .cmd, .cmp_idx, .out_idx,
    .rd_radius, .rd_angle, .res(out_ch)
  );

  pas_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .coord_x(in_ch.coord_x), .coord_y(in_ch.coord_y),
    .tol(tol_r), .cmp_idx, .out_idx, .rd_radius, .rd_angle, .drop, .count
  );
endmodule

/* rtl/pas_checker.sv */
// Port-level checker for the polar angle sort, bound to the top level.
`include "polar_angle_sort_macros.svh"
module pas_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic final_point
);
  `PAS_ASSERT_IMP(a_no_in_while_out, out_valid, !in_ready, "input taken during output")
  `PAS_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid, "output word dropped")
  `PAS_ASSERT_NXT(a_set_closes, out_valid && out_ready && final_point, !out_valid, "word after final")
endmodule

bind polar_angle_sort pas_checker u_pas_checker (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .final_point(out_ch.final_point)
);
